/* rtl/qphs_pkg.sv */
// Shared constants, payload words and control structs for the quadratic probe hash set.
package qphs_pkg;

    localparam int COORD_BITS     = 10;
    // The table size is a power of two, so the slot index is the low bits of the hash.
    localparam int TABLE_SIZE     = 1048576;
    localparam int MAX_PROBES     = 64;

    localparam int IDX_BITS       = $clog2(TABLE_SIZE);
    localparam int KEY_BITS       = 4 * COORD_BITS;
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;
    localparam int COUNT_BITS     = 21;
    localparam int PROBE_BITS     = $clog2(MAX_PROBES + 1);
    localparam int SQ_BITS        = 2 * PROBE_BITS;
    localparam int SUM_BITS       = (IDX_BITS > SQ_BITS) ? IDX_BITS + 1 : SQ_BITS + 1;

    localparam logic [CFG_BITS-1:0]       CFG_RESET     = CFG_BITS'(1024);
    localparam logic [COUNT_BITS-1:0]     COUNT_MAX     = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_CLEAR,
        OUTCOME_FOUND,
        OUTCOME_INSERTED,
        OUTCOME_FULL
    } outcome_t;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] first_row;
        logic [COORD_BITS-1:0] first_col;
        logic [COORD_BITS-1:0] second_row;
        logic [COORD_BITS-1:0] second_col;
    } in_word_t;

    typedef struct packed {
        logic                  found;
        logic                  inserted;
        logic                  table_full;
        logic [COUNT_BITS-1:0] distinct_count;
    } out_word_t;

    typedef struct packed {
        logic     load;
        logic     clr_start;
        logic     clr_step;
        logic     hash1;
        logic     hash2;
        logic     insert;
        logic     step;
        logic     out_load;
        outcome_t outcome;
    } dp_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic clr_last;
        logic used;
        logic match;
        logic last_probe;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/qphs_datapath.sv */
// Datapath: key canonicalization, hash, probe stepping, slot memory, count and result register.
module qphs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qphs_pkg::in_word_t                  s_data,
    input  logic                                cfg_wr_en,
    input  logic [qphs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [qphs_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  qphs_pkg::dp_cmd_t                   cmd,
    output qphs_pkg::dp_status_t                status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output qphs_pkg::out_word_t                 m_data
);

    localparam int IDX   = qphs_pkg::IDX_BITS;
    localparam int CB    = qphs_pkg::COORD_BITS;
    localparam int KB    = qphs_pkg::KEY_BITS;
    localparam int PB    = qphs_pkg::PROBE_BITS;
    localparam int SQB   = qphs_pkg::SQ_BITS;
    localparam int SUMB  = qphs_pkg::SUM_BITS;
    localparam int DEPTH = qphs_pkg::TABLE_SIZE;

    logic [qphs_pkg::CFG_BITS-1:0]   row_count_reg, col_count_reg;
    logic [KB-1:0]                   key_reg, key_next;
    logic [IDX-1:0]                  a_reg, a_next, b_reg, b_next, span_reg, span_next;
    logic [IDX-1:0]                  slot_reg, slot_next;
    logic [PB-1:0]                   probe_reg;
    logic [SQB-1:0]                  probe_sq;
    logic [IDX-1:0]                  clr_addr_reg;
    logic [qphs_pkg::COUNT_BITS-1:0] count_reg;
    logic [KB:0]                     mem [DEPTH];
    logic [KB:0]                     rd_reg;
    logic                            wr_en;
    logic [IDX-1:0]                  wr_addr;
    logic [KB:0]                     wr_data;
    logic                            m_valid_reg;
    qphs_pkg::out_word_t             m_data_reg;
    logic [CB-1:0]                   kr1, kc1, kr2, kc2;
    logic                            swap;

    // Canonical order: smaller row first, then smaller column on equal rows.
    always_comb begin
        swap = (s_data.first_row > s_data.second_row) ||
               ((s_data.first_row == s_data.second_row) &&
                (s_data.first_col > s_data.second_col));
        if (swap) begin
            key_next = {s_data.second_row, s_data.second_col,
                        s_data.first_row, s_data.first_col};
        end else begin
            key_next = {s_data.first_row, s_data.first_col,
                        s_data.second_row, s_data.second_col};
        end
    end

    assign kr1 = key_reg[4*CB-1:3*CB];
    assign kc1 = key_reg[3*CB-1:2*CB];
    assign kr2 = key_reg[2*CB-1:CB];
    assign kc2 = key_reg[CB-1:0];

    // All hash arithmetic is taken modulo the table size.
    always_comb begin
        a_next    = IDX'(kr1) * IDX'(col_count_reg) + IDX'(kc1);
        b_next    = IDX'(kr2) * IDX'(col_count_reg) + IDX'(kc2);
        span_next = IDX'(row_count_reg) * IDX'(col_count_reg);
        probe_sq  = SQB'(probe_reg) * SQB'(probe_reg);
        if (cmd.hash2) begin
            slot_next = a_reg * span_reg + b_reg;
        end else begin
            slot_next = IDX'(SUMB'(slot_reg) + SUMB'(probe_sq));
        end
    end

    always_comb begin
        wr_en   = cmd.clr_step || cmd.insert;
        wr_addr = cmd.clr_step ? clr_addr_reg : slot_reg;
        wr_data = cmd.clr_step ? '0 : {1'b1, key_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= qphs_pkg::CFG_RESET;
            col_count_reg <= qphs_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                qphs_pkg::REG_ROW_COUNT: row_count_reg <= cfg_wr_data;
                qphs_pkg::REG_COL_COUNT: col_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_next;
        end
        if (cmd.hash1) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            span_reg <= span_next;
        end
        if (cmd.hash2 || cmd.step) begin
            slot_reg <= slot_next;
        end
        if (cmd.hash2) begin
            probe_reg <= PB'(1);
        end else if (cmd.step) begin
            probe_reg <= probe_reg + PB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
                count_reg    <= '0;
            end else if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + IDX'(1);
            end else if (cmd.insert && (count_reg != qphs_pkg::COUNT_MAX)) begin
                count_reg <= count_reg + qphs_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.found          <= (cmd.outcome == qphs_pkg::OUTCOME_FOUND);
            m_data_reg.inserted       <= (cmd.outcome == qphs_pkg::OUTCOME_INSERTED);
            m_data_reg.table_full     <= (cmd.outcome == qphs_pkg::OUTCOME_FULL);
            m_data_reg.distinct_count <= count_reg;
        end
    end

    always_comb begin
        status.in_clear   = s_data.action;
        status.clr_last   = &clr_addr_reg;
        status.used       = rd_reg[KB];
        status.match      = (rd_reg[KB-1:0] == key_reg);
        status.last_probe = (probe_reg == PB'(qphs_pkg::MAX_PROBES));
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && (count_reg != qphs_pkg::COUNT_MAX)) |=>
        (count_reg == $past(count_reg) + qphs_pkg::COUNT_BITS'(1)))
        else $error("count did not advance on insert");

    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |->
        ($countones({m_data_reg.found, m_data_reg.inserted, m_data_reg.table_full}) <= 1))
        else $error("more than one outcome flag set");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.inserted) |-> (m_data_reg.distinct_count != '0))
        else $error("insert reported with zero count");

endmodule

/* rtl/qphs_ctrl.sv */
// Controller state machine: sequences clearing, hashing, probing and result delivery.
module qphs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qphs_pkg::dp_status_t status,
    output qphs_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_HASH1 = 3'd2;
    localparam logic [2:0] ST_HASH2 = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               clr_reply_reg, clr_reply_next;
    qphs_pkg::outcome_t outcome_reg, outcome_next;
    logic               accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        clr_reply_next = clr_reply_reg;
        outcome_next   = outcome_reg;
        cmd            = '0;
        cmd.outcome    = outcome_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (status.in_clear) begin
                        cmd.clr_start  = 1'b1;
                        clr_reply_next = 1'b1;
                        outcome_next   = qphs_pkg::OUTCOME_CLEAR;
                        state_next     = ST_CLEAR;
                    end else begin
                        state_next = ST_HASH1;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_HASH1: begin
                cmd.hash1  = 1'b1;
                state_next = ST_HASH2;
            end
            ST_HASH2: begin
                cmd.hash2  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (!status.used) begin
                    cmd.insert   = 1'b1;
                    outcome_next = qphs_pkg::OUTCOME_INSERTED;
                    state_next   = ST_DONE;
                end else if (status.match) begin
                    outcome_next = qphs_pkg::OUTCOME_FOUND;
                    state_next   = ST_DONE;
                end else if (status.last_probe) begin
                    outcome_next = qphs_pkg::OUTCOME_FULL;
                    state_next   = ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reply_reg <= 1'b0;
            outcome_reg   <= qphs_pkg::OUTCOME_CLEAR;
        end else begin
            state_reg     <= state_next;
            clr_reply_reg <= clr_reply_next;
            outcome_reg   <= outcome_next;
        end
    end

    a_check_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_READ))
        else $error("slot checked without a preceding read");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.clr_step))
        else $error("insert and clearing write in the same cycle");

endmodule

/* rtl/quadratic_probe_hash_set.sv */
// Top level of the quadratic probe hash set: controller and datapath.
// Each word is an insert-if-absent of a canonical cell pair, or a clear. After reset the
// slot memory is swept once, one slot per cycle over all TABLE_SIZE (1048576 here) slots,
// and no word is taken until that sweep ends; a clear word runs the same sweep and then
// returns its result. An insert word passes through two hash-multiply states, then per
// probe (1 to MAX_PROBES slots) a registered slot-memory read state and a compare state,
// then a state that loads the result register once that register is free. A finished
// result waits in that register without holding up acceptance of the next word.
module quadratic_probe_hash_set (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  qphs_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output qphs_pkg::out_word_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [qphs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [qphs_pkg::CFG_BITS-1:0]       cfg_wr_data
);

    qphs_pkg::dp_cmd_t    cmd;
    qphs_pkg::dp_status_t status;

    qphs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qphs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

/* sim/tb_quadratic_probe_hash_set.sv */
// Self-checking testbench for the quadratic probe hash set with a shadow set as predictor.
module tb_quadratic_probe_hash_set;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = qphs_pkg::COORD_BITS;
    localparam int CW = qphs_pkg::CFG_BITS;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    qphs_pkg::in_word_t                  s_data      = '0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    qphs_pkg::out_word_t                 m_data;
    logic                                cfg_wr_en   = 1'b0;
    logic [qphs_pkg::CFG_INDEX_BITS-1:0] cfg_index   = qphs_pkg::REG_ROW_COUNT;
    logic [CW-1:0]                       cfg_wr_data = '0;

    logic [qphs_pkg::KEY_BITS-1:0]   shadow_keys [int unsigned];
    logic [qphs_pkg::COUNT_BITS-1:0] shadow_total = '0;
    logic [CW-1:0]                   grid_rows    = qphs_pkg::CFG_RESET;
    logic [CW-1:0]                   grid_cols    = qphs_pkg::CFG_RESET;
    qphs_pkg::out_word_t             pending_outcomes [$];
    qphs_pkg::in_word_t              key_pool [$];
    int                              mismatch_count = 0;
    int                              burst_left     = 1;
    int                              hold_cycles    = 0;

    quadratic_probe_hash_set dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic qphs_pkg::out_word_t predict_access(qphs_pkg::in_word_t w);
        logic [CB-1:0]                 r1, c1, r2, c2, t;
        logic [qphs_pkg::KEY_BITS-1:0] key;
        longint unsigned               ur1, uc1, ur2, uc2, rows, cols, cell_idx, span, h;
        int unsigned                   slot;
        qphs_pkg::out_word_t           res;
        res = '0;
        if (w.action) begin
            shadow_keys.delete();
            shadow_total = '0;
            return res;
        end
        r1 = w.first_row;
        c1 = w.first_col;
        r2 = w.second_row;
        c2 = w.second_col;
        if (r1 > r2) begin
            t = r1; r1 = r2; r2 = t;
            t = c1; c1 = c2; c2 = t;
        end
        if (r1 == r2 && c1 > c2) begin
            t = c1; c1 = c2; c2 = t;
        end
        key      = {r1, c1, r2, c2};
        ur1      = r1;
        uc1      = c1;
        ur2      = r2;
        uc2      = c2;
        rows     = grid_rows;
        cols     = grid_cols;
        cell_idx = ur1 * cols + uc1;
        span     = rows * cols;
        h        = cell_idx * span + ur2 * cols + uc2;
        slot     = 32'(h % qphs_pkg::TABLE_SIZE);
        res.table_full = 1'b1;
        for (int k = 1; k <= qphs_pkg::MAX_PROBES; k++) begin
            if (!shadow_keys.exists(slot)) begin
                shadow_keys[slot] = key;
                if (shadow_total < qphs_pkg::COUNT_MAX) shadow_total = shadow_total + 1'b1;
                res.inserted   = 1'b1;
                res.table_full = 1'b0;
                break;
            end
            if (shadow_keys[slot] == key) begin
                res.found      = 1'b1;
                res.table_full = 1'b0;
                break;
            end
            slot = (slot + k * k) % qphs_pkg::TABLE_SIZE;
        end
        res.distinct_count = shadow_total;
        return res;
    endfunction

    function automatic qphs_pkg::in_word_t key_of(int r1, int c1, int r2, int c2);
        qphs_pkg::in_word_t w;
        w.action     = 1'b0;
        w.first_row  = CB'(r1);
        w.first_col  = CB'(c1);
        w.second_row = CB'(r2);
        w.second_col = CB'(c2);
        return w;
    endfunction

    function automatic qphs_pkg::in_word_t fresh_key(int hi);
        return key_of($urandom_range(0, hi), $urandom_range(0, hi),
                      $urandom_range(0, hi), $urandom_range(0, hi));
    endfunction

    function automatic qphs_pkg::in_word_t clear_word();
        qphs_pkg::in_word_t w;
        w = fresh_key(1023);
        w.action = 1'b1;
        return w;
    endfunction

    // Starts at a falling edge and returns at the falling edge after the word is taken.
    task automatic send_word(qphs_pkg::in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(predict_access(w));
        @(negedge aclk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic send_paced(qphs_pkg::in_word_t w);
        send_word(w);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_grid(logic [CW-1:0] rows, logic [CW-1:0] cols);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= qphs_pkg::REG_ROW_COUNT;
        cfg_wr_data <= rows;
        @(negedge aclk);
        cfg_index   <= qphs_pkg::REG_COL_COUNT;
        cfg_wr_data <= cols;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        grid_rows = rows;
        grid_cols = cols;
    endtask

    task automatic mixed_traffic(int n, int hi, int reuse_pct);
        qphs_pkg::in_word_t w, s;
        for (int i = 0; i < n; i++) begin
            if (key_pool.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
                w = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if ($urandom_range(0, 1)) begin
                    s = w;
                    w.first_row  = s.second_row;
                    w.first_col  = s.second_col;
                    w.second_row = s.first_row;
                    w.second_col = s.first_col;
                end
            end else begin
                w = fresh_key(hi);
                key_pool.push_back(w);
                if (key_pool.size() > 200) void'(key_pool.pop_front());
            end
            send_paced(w);
        end
    endtask

    task automatic test_directed_keys();
        send_paced(key_of(0, 0, 0, 0));
        send_paced(key_of(0, 0, 0, 0));
        send_paced(key_of(1023, 1023, 1023, 1023));
        send_paced(key_of(1023, 0, 0, 1023));
        send_paced(key_of(0, 1023, 1023, 0));
        send_paced(key_of(5, 900, 5, 3));
        send_paced(key_of(5, 3, 5, 900));
        send_paced(key_of(512, 1, 512, 1));
        send_paced(key_of(10'h2AA, 10'h155, 10'h155, 10'h2AA));
        send_paced(key_of(10'h155, 10'h2AA, 10'h2AA, 10'h155));
    endtask

    task automatic test_clear();
        send_paced(clear_word());
        send_paced(key_of(0, 0, 0, 0));
        send_paced(key_of(1023, 1023, 1023, 1023));
    endtask

    task automatic test_grid_extremes();
        set_grid(11'd2047, 11'd2047);
        send_paced(key_of(1023, 1023, 0, 0));
        send_paced(key_of(0, 0, 1023, 1023));
        set_grid(11'd1, 11'd1);
        // Both keys hash to the same slot, so the second one probes onward.
        send_paced(key_of(3, 4, 2, 5));
        send_paced(key_of(3, 3, 2, 6));
        send_paced(key_of(2, 6, 3, 3));
        send_paced(key_of(0, 0, 0, 0));
    endtask

    task automatic test_random_default();
        set_grid(qphs_pkg::CFG_RESET, qphs_pkg::CFG_RESET);
        mixed_traffic(300, 1023, 40);
        mixed_traffic(200, 7, 30);
    endtask

    // With both counts at zero the home slot is the canonical second column, so keys
    // that share it share one probe chain until the probe limit is reached.
    task automatic test_probe_limit();
        set_grid(11'd0, 11'd0);
        key_pool.delete();
        for (int i = 0; i < 100; i++) begin
            send_paced(key_of($urandom_range(0, 1022), $urandom_range(0, 1023), 1023, 0));
        end
        mixed_traffic(50, 1023, 65);
        send_paced(clear_word());
        key_pool.delete();
        mixed_traffic(150, 1023, 65);
    endtask

    task automatic test_small_grids();
        for (int i = 0; i < 3; i++) begin
            set_grid(CW'($urandom_range(1, 8)), CW'($urandom_range(1, 8)));
            mixed_traffic(150, 15, 35);
        end
    endtask

    task automatic test_wide_grids();
        set_grid(11'd2047, 11'd2047);
        mixed_traffic(200, 1023, 40);
        set_grid(CW'($urandom_range(0, 2047)), CW'($urandom_range(0, 2047)));
        mixed_traffic(200, 1023, 40);
    endtask

    task automatic test_backpressure();
        set_grid(11'd1024, 11'd1);
        hold_cycles = 600;
        for (int i = 0; i < 40; i++) send_word(fresh_key(63));
        drain_results();
        mixed_traffic(30, 63, 50);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_keys();
        test_clear();
        test_grid_extremes();
        test_random_default();
        test_probe_limit();
        test_small_grids();
        test_wide_grids();
        test_backpressure();
        drain_results();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= ((phase % 9) < 5);
                endcase
            end
        end
    end

    initial begin
        qphs_pkg::out_word_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result word with no pending expectation: %h", m_data);
                    mismatch_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_data.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_data.found);
                        mismatch_count++;
                    end
                    if (m_data.inserted !== want.inserted) begin
                        $error("inserted: expected %0d, actual %0d",
                               want.inserted, m_data.inserted);
                        mismatch_count++;
                    end
                    if (m_data.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, actual %0d",
                               want.table_full, m_data.table_full);
                        mismatch_count++;
                    end
                    if (m_data.distinct_count !== want.distinct_count) begin
                        $error("distinct_count: expected %0d, actual %0d",
                               want.distinct_count, m_data.distinct_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // The reset sweep and each clear both walk every slot of the slot memory.
    initial begin
        #200000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
